@@ hw/rtl/cbtp_pkg.sv @@
// Shared types, constants and helper functions of the color bar test pattern block.
`default_nettype none

package cbtp_pkg;

    // Frame geometry
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SIZE_W      = 13;
    localparam int COORD_W     = 12;
    localparam int FRAME_W     = 32;
    localparam int COLOR_W     = 24;

    // Configuration port
    localparam int CFG_IDX_W   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 8'd0,
        CFG_FRAME_HEIGHT = 8'd1
    } t_cfg_reg;

    // Pattern constants
    localparam int BAR_SHIFT    = 3;    // eight bars per line
    localparam int MARKER_WIDTH = 8;
    localparam int BAND_HEIGHT  = 6;
    localparam logic [COLOR_W-1:0] MARKER_COLOR = 24'hff8000;

    // Remainder divider geometry: 36 dividend bits, four steps per stage
    localparam int DIV_STEPS   = 36;
    localparam int STAGE_STEPS = 4;
    localparam int DIV_STAGES  = DIV_STEPS / STAGE_STEPS;
    localparam int REM_W       = SIZE_W;
    localparam int BAR_IDX_W   = 3;

    // One pixel traveling through the divider stages
    typedef struct packed {
        logic                 valid;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [DIV_STEPS-1:0] num_m;    // frame*4, marker column dividend
        logic [DIV_STEPS-1:0] num_b;    // frame*3, band line dividend
        logic [DIV_STEPS-1:0] num_x;    // pixel column, bar dividend
        logic [REM_W-1:0]     rem_m;
        logic [REM_W-1:0]     rem_b;
        logic [REM_W-1:0]     rem_x;
        logic [BAR_IDX_W-1:0] quo_x;    // low quotient bits = bar index
    } t_div_pipe;

    // Result of one restoring division step
    typedef struct packed {
        logic             q;
        logic [REM_W-1:0] rem;
    } t_div_step;

    // Clamp a size register to 1..max
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max);
        logic [SIZE_W-1:0] res;
        begin
            if (v == '0) begin
                res = SIZE_W'(1);
            end else if (v > max) begin
                res = max;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

    // One restoring step: shift in a bit, subtract divisor if it fits
    function automatic t_div_step div_step(input logic [REM_W-1:0] rem,
                                           input logic             nbit,
                                           input logic [SIZE_W-1:0] d);
        logic [REM_W:0] sh;
        t_div_step      res;
        begin
            sh = {rem, nbit};
            if (sh >= {1'b0, d}) begin
                res.q   = 1'b1;
                res.rem = REM_W'(sh - {1'b0, d});
            end else begin
                res.q   = 1'b0;
                res.rem = sh[REM_W-1:0];
            end
            return res;
        end
    endfunction

    // Bar color table: white, yellow, cyan, green, magenta, red, blue, black
    function automatic logic [COLOR_W-1:0] bar_color(input logic [BAR_IDX_W-1:0] idx);
        logic [COLOR_W-1:0] c;
        begin
            case (idx)
                3'd0:    c = 24'hffffff;
                3'd1:    c = 24'hffff00;
                3'd2:    c = 24'h00ffff;
                3'd3:    c = 24'h00ff00;
                3'd4:    c = 24'hff00ff;
                3'd5:    c = 24'hff0000;
                3'd6:    c = 24'h0000ff;
                default: c = 24'h000000;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cbtp_cfg_regs.sv @@
// Configuration registers: frame width and height, stored already clamped.
`default_nettype none

module cbtp_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cbtp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cbtp_pkg::SIZE_W-1:0]     i_cfg_data,
    output logic      [cbtp_pkg::SIZE_W-1:0]     o_width,
    output logic      [cbtp_pkg::SIZE_W-1:0]     o_height
);

    logic [cbtp_pkg::SIZE_W-1:0] r_width, n_width;
    logic [cbtp_pkg::SIZE_W-1:0] r_height, n_height;

    // Decode writes; unknown indexes are dropped
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (i_cfg_index)
                cbtp_pkg::CFG_FRAME_WIDTH: begin
                    n_width = cbtp_pkg::clamp_size(i_cfg_data,
                                  cbtp_pkg::SIZE_W'(cbtp_pkg::MAX_WIDTH));
                end
                cbtp_pkg::CFG_FRAME_HEIGHT: begin
                    n_height = cbtp_pkg::clamp_size(i_cfg_data,
                                   cbtp_pkg::SIZE_W'(cbtp_pkg::MAX_HEIGHT));
                end
                default: begin
                    n_width  = r_width;
                    n_height = r_height;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cbtp_pkg::SIZE_W'(1920);
            r_height <= cbtp_pkg::SIZE_W'(1080);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

`default_nettype wire

@@ hw/rtl/cbtp_div_stage.sv @@
// One divider pipeline stage: four restoring steps of each of the three remainders.
`default_nettype none

module cbtp_div_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic [cbtp_pkg::SIZE_W-1:0] i_width,
    input  wire logic [cbtp_pkg::SIZE_W-1:0] i_height,
    input  wire cbtp_pkg::t_div_pipe         i_pipe,
    output cbtp_pkg::t_div_pipe              o_pipe
);

    cbtp_pkg::t_div_pipe r_pipe, n_pipe;
    logic [cbtp_pkg::SIZE_W-1:0] w_bar_width;

    assign w_bar_width = i_width >> cbtp_pkg::BAR_SHIFT;

    // Four dependent steps, MSB of each dividend first
    always_comb begin
        cbtp_pkg::t_div_step s_m, s_b, s_x;
        n_pipe = i_pipe;
        for (int i = 0; i < cbtp_pkg::STAGE_STEPS; i++) begin
            s_m = cbtp_pkg::div_step(n_pipe.rem_m, n_pipe.num_m[cbtp_pkg::DIV_STEPS-1],
                                     i_width);
            s_b = cbtp_pkg::div_step(n_pipe.rem_b, n_pipe.num_b[cbtp_pkg::DIV_STEPS-1],
                                     i_height);
            s_x = cbtp_pkg::div_step(n_pipe.rem_x, n_pipe.num_x[cbtp_pkg::DIV_STEPS-1],
                                     w_bar_width);
            n_pipe.rem_m = s_m.rem;
            n_pipe.rem_b = s_b.rem;
            n_pipe.rem_x = s_x.rem;
            n_pipe.num_m = n_pipe.num_m << 1;
            n_pipe.num_b = n_pipe.num_b << 1;
            n_pipe.num_x = n_pipe.num_x << 1;
            n_pipe.quo_x = {n_pipe.quo_x[cbtp_pkg::BAR_IDX_W-2:0], s_x.q};
        end
    end

    // Only valid is reset; the whole transaction moves on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_adv) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule

`default_nettype wire

@@ hw/rtl/cbtp_color.sv @@
// Final stage: marker and band span tests, bar color lookup and the output register.
`default_nettype none

module cbtp_color (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_adv,
    input  wire logic [cbtp_pkg::SIZE_W-1:0]  i_width,
    input  wire logic [cbtp_pkg::SIZE_W-1:0]  i_height,
    input  wire cbtp_pkg::t_div_pipe          i_pipe,
    output logic                              o_valid,
    output logic      [cbtp_pkg::COLOR_W-1:0] o_color
);

    logic                         r_valid;
    logic [cbtp_pkg::COLOR_W-1:0] r_color, n_color;
    logic [cbtp_pkg::SIZE_W-1:0]  w_x, w_y, w_end_m, w_end_b;
    logic                         w_in_marker, w_in_band;
    logic [cbtp_pkg::BAR_IDX_W-1:0] w_bar;

    assign w_x = {1'b0, i_pipe.x};
    assign w_y = {1'b0, i_pipe.y};

    // Span ends; start is below size so no overflow in 13 bits
    assign w_end_m = i_pipe.rem_m + cbtp_pkg::SIZE_W'(cbtp_pkg::MARKER_WIDTH);
    assign w_end_b = i_pipe.rem_b + cbtp_pkg::SIZE_W'(cbtp_pkg::BAND_HEIGHT);

    // Wrapped span tests
    assign w_in_marker = ((w_x >= i_pipe.rem_m) && (w_x < w_end_m)) ||
                         ((w_end_m > i_width) && (w_x < (w_end_m - i_width)));
    assign w_in_band   = ((w_y >= i_pipe.rem_b) && (w_y < w_end_b)) ||
                         ((w_end_b > i_height) && (w_y < (w_end_b - i_height)));

    // Narrow frames have a zero bar width: everything is bar 0
    assign w_bar = ((i_width >> cbtp_pkg::BAR_SHIFT) == '0) ? '0 : i_pipe.quo_x;

    always_comb begin
        n_color = cbtp_pkg::bar_color(w_bar);
        if (w_in_marker) begin
            n_color = cbtp_pkg::MARKER_COLOR;
        end
        if (w_in_band) begin
            n_color = ~n_color;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_pipe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_color <= n_color;
        end
    end

    assign o_valid = r_valid;
    assign o_color = r_color;

endmodule

`default_nettype wire

@@ hw/rtl/color_bar_test_pattern_top.sv @@
// Top level of the color bar test pattern generator.
//
// Input channel: i_valid / o_stall carry one pixel (i_pixel_x, i_pixel_y,
// i_frame_number); a transaction completes on a clock edge with i_valid high
// and o_stall low. Output channel: o_valid / i_stall carry o_pixel_color.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 = frame width, 1 = frame height); sizes are clamped to 1..4096 on write.
// Write them only while the pipeline is empty.
//
// Throughput is one pixel per clock while i_stall does not hold the pipeline.
// From input transaction to output valid, the entry register captures the
// transaction, then nine divider stages (four restoring steps each, 36 steps
// in all for frame*4 mod width, frame*3 mod height and x / (width/8)), then
// the color/output register.
//
// When the receiver stalls with a result pending, the whole pipeline holds
// and o_stall rises; nothing is dropped or repeated. Reset clears all valid
// bits and loads width 1920, height 1080.
`default_nettype none

module color_bar_test_pattern_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [cbtp_pkg::COORD_W-1:0]    i_pixel_x,
    input  wire logic [cbtp_pkg::COORD_W-1:0]    i_pixel_y,
    input  wire logic [cbtp_pkg::FRAME_W-1:0]    i_frame_number,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [cbtp_pkg::COLOR_W-1:0]    o_pixel_color,
    input  wire logic                            i_cfg_we,
    input  wire logic [cbtp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cbtp_pkg::SIZE_W-1:0]     i_cfg_data
);

    logic [cbtp_pkg::SIZE_W-1:0] w_width, w_height;
    logic                        w_adv;
    cbtp_pkg::t_div_pipe         r_entry, n_entry;
    cbtp_pkg::t_div_pipe         w_pipe [cbtp_pkg::DIV_STAGES+1];

    cbtp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_width     (w_width),
        .o_height    (w_height)
    );

    // Whole pipeline holds while a finished result waits
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // Entry stage: build the dividends
    always_comb begin
        n_entry       = '0;
        n_entry.valid = i_valid;
        n_entry.x     = i_pixel_x;
        n_entry.y     = i_pixel_y;
        n_entry.num_m = {2'b00, i_frame_number, 2'b00};
        n_entry.num_b = {4'b0000, i_frame_number} + {3'b000, i_frame_number, 1'b0};
        n_entry.num_x = {{(cbtp_pkg::DIV_STEPS-cbtp_pkg::COORD_W){1'b0}}, i_pixel_x};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (w_adv) begin
            r_entry <= n_entry;
        end
    end

    assign w_pipe[0] = r_entry;

    // Divider stages
    for (genvar g = 0; g < cbtp_pkg::DIV_STAGES; g++) begin : g_div
        cbtp_div_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_width  (w_width),
            .i_height (w_height),
            .i_pipe   (w_pipe[g]),
            .o_pipe   (w_pipe[g+1])
        );
    end

    cbtp_color u_color (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_width  (w_width),
        .i_height (w_height),
        .i_pipe   (w_pipe[cbtp_pkg::DIV_STAGES]),
        .o_valid  (o_valid),
        .o_color  (o_pixel_color)
    );

endmodule

`default_nettype wire
